/* design/ofifo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared types and sizes of the overwrite-oldest message FIFO.
// ----------------------------------------------------------------------------
package ofifo_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int MSG_BYTES   = 64;

    localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
    localparam int LEN_W      = $clog2(MSG_BYTES + 1);
    localparam int CNT_W      = 8;
    localparam int BYTE_DEPTH = QUEUE_DEPTH * MSG_BYTES;
    localparam int BYTE_AW    = $clog2(BYTE_DEPTH);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_FLUSH   = 2'd2,
        OP_CLOSE   = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
        logic       end_of_message;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_last;
        logic             was_empty;
        logic             dropped_oldest;
        logic             truncated;
        logic [CNT_W-1:0] entries;
        logic             is_full;
    } rsp_beat_t;

    typedef struct packed {
        logic               byte_we;
        logic [BYTE_AW-1:0] byte_waddr;
        logic [7:0]         byte_wdata;
        logic [BYTE_AW-1:0] byte_raddr;
        logic               len_we;
        logic [SLOT_W-1:0]  len_waddr;
        logic [LEN_W-1:0]   len_wdata;
        logic [SLOT_W-1:0]  len_raddr;
    } mem_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] depth;
    } ctrl_status_t;

endpackage
`default_nettype wire

/* design/ofifo_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ofifo_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ofifo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* design/ofifo_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ofifo_ctrl
// Queue pointers, message write tracking, dequeue streaming sequencer and
// result register.
// ----------------------------------------------------------------------------
module ofifo_ctrl import ofifo_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_stall,
    input  wire cmd_beat_t    cmd,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output rsp_beat_t         rsp,
    input  wire logic         cfg_we,
    input  wire logic [7:0]   cfg_wdata,
    output mem_req_t          mem_req,
    input  wire logic [7:0]   byte_rdata,
    input  wire logic [LEN_W-1:0] len_rdata,
    output ctrl_status_t      status
);

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] slot,
                                                     input logic [CNT_W-1:0]  depth);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(slot) + (CNT_W+1)'(1);
        return (nxt >= (CNT_W+1)'(depth)) ? '0 : SLOT_W'(nxt);
    endfunction

    function automatic logic [BYTE_AW-1:0] byte_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [LEN_W-1:0]  off);
        return BYTE_AW'(slot) * BYTE_AW'(MSG_BYTES) + BYTE_AW'(off);
    endfunction

    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [SLOT_W-1:0] oldest_reg,    oldest_next;
    logic [SLOT_W-1:0] newest_reg,    newest_next;
    logic              writing_reg,   writing_next;
    logic [LEN_W-1:0]  offset_reg,    offset_next;
    logic              overflow_reg,  overflow_next;
    logic              overwrite_reg, overwrite_next;
    logic [CNT_W-1:0]  depth_reg,     depth_next;
    logic [SLOT_W-1:0] cur_slot_reg,  cur_slot_next;
    logic [LEN_W-1:0]  rd_idx_reg,    rd_idx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_beat_t         rsp_reg,       rsp_next;

    logic              out_ready;
    logic              accept;
    logic [SLOT_W-1:0] enq_slot;
    logic [LEN_W-1:0]  enq_off;
    logic              enq_last;
    logic [CNT_W-1:0]  cfg_depth;

    assign out_ready = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || !out_ready;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign status.busy        = (state_reg == ST_STREAM);
    assign status.entry_count = count_reg;
    assign status.depth       = depth_reg;

    always_comb
    begin
        if (cfg_wdata == 8'd0)
        begin
            cfg_depth = CNT_W'(1);
        end
        else if (32'(cfg_wdata) > QUEUE_DEPTH)
        begin
            cfg_depth = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            cfg_depth = cfg_wdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        newest_next    = newest_reg;
        writing_next   = writing_reg;
        offset_next    = offset_reg;
        overflow_next  = overflow_reg;
        overwrite_next = overwrite_reg;
        depth_next     = depth_reg;
        cur_slot_next  = cur_slot_reg;
        rd_idx_next    = rd_idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        enq_slot       = newest_reg;
        enq_off        = offset_reg;
        enq_last       = 1'b0;

        mem_req.byte_we    = 1'b0;
        mem_req.byte_waddr = byte_addr(newest_reg, offset_reg);
        mem_req.byte_wdata = cmd.data_byte;
        mem_req.byte_raddr = byte_addr(oldest_reg, '0);
        mem_req.len_we     = 1'b0;
        mem_req.len_waddr  = newest_reg;
        mem_req.len_wdata  = offset_reg;
        mem_req.len_raddr  = oldest_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        OP_ENQUEUE:
                        begin
                            if (!writing_reg)
                            begin
                                enq_slot = (count_reg == '0) ? '0
                                                             : slot_after(newest_reg, depth_reg);
                                enq_off  = '0;
                                if (count_reg == '0)
                                begin
                                    oldest_next = '0;
                                end
                                if (count_reg >= depth_reg)
                                begin
                                    overwrite_next = 1'b1;
                                    oldest_next    = slot_after(enq_slot, depth_reg);
                                end
                                else
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            newest_next = enq_slot;
                            offset_next = enq_off;
                            if (32'(enq_off) < MSG_BYTES)
                            begin
                                offset_next        = enq_off + LEN_W'(1);
                                mem_req.byte_we    = 1'b1;
                                mem_req.byte_waddr = byte_addr(enq_slot, enq_off);
                                mem_req.len_we     = 1'b1;
                                mem_req.len_waddr  = enq_slot;
                                mem_req.len_wdata  = enq_off + LEN_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                            rsp_valid_next          = 1'b1;
                            rsp_next.out_byte       = 8'd0;
                            rsp_next.out_last       = 1'b1;
                            rsp_next.was_empty      = 1'b0;
                            rsp_next.dropped_oldest = overwrite_next;
                            rsp_next.truncated      = overflow_next;
                            rsp_next.entries        = count_next;
                            rsp_next.is_full        = (count_next >= depth_reg);
                            writing_next            = 1'b1;
                            if (cmd.end_of_message)
                            begin
                                writing_next   = 1'b0;
                                offset_next    = '0;
                                overflow_next  = 1'b0;
                                overwrite_next = 1'b0;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            writing_next   = 1'b0;
                            offset_next    = '0;
                            overflow_next  = 1'b0;
                            overwrite_next = 1'b0;
                            if (count_reg == '0)
                            begin
                                rsp_valid_next          = 1'b1;
                                rsp_next.out_byte       = 8'd0;
                                rsp_next.out_last       = 1'b1;
                                rsp_next.was_empty      = 1'b1;
                                rsp_next.dropped_oldest = 1'b0;
                                rsp_next.truncated      = 1'b0;
                                rsp_next.entries        = count_reg;
                                rsp_next.is_full        = (count_reg >= depth_reg);
                            end
                            else
                            begin
                                oldest_next   = slot_after(oldest_reg, depth_reg);
                                count_next    = count_reg - CNT_W'(1);
                                cur_slot_next = oldest_reg;
                                rd_idx_next   = '0;
                                state_next    = ST_STREAM;
                            end
                        end
                        OP_FLUSH:
                        begin
                            count_next              = '0;
                            oldest_next             = '0;
                            newest_next             = '0;
                            writing_next            = 1'b0;
                            offset_next             = '0;
                            overflow_next           = 1'b0;
                            overwrite_next          = 1'b0;
                            rsp_valid_next          = 1'b1;
                            rsp_next.out_byte       = 8'd0;
                            rsp_next.out_last       = 1'b1;
                            rsp_next.was_empty      = 1'b0;
                            rsp_next.dropped_oldest = 1'b0;
                            rsp_next.truncated      = 1'b0;
                            rsp_next.entries        = '0;
                            rsp_next.is_full        = ('0 >= depth_reg);
                        end
                        OP_CLOSE:
                        begin
                            writing_next   = 1'b0;
                            offset_next    = '0;
                            overflow_next  = 1'b0;
                            overwrite_next = 1'b0;
                        end
                        default:
                        begin
                            writing_next = writing_reg;
                        end
                    endcase
                end
            end
            ST_STREAM:
            begin
                // len_rdata and byte_rdata hold the current slot's length and byte
                mem_req.len_raddr  = cur_slot_reg;
                mem_req.byte_raddr = byte_addr(cur_slot_reg, rd_idx_reg);
                enq_last = (len_rdata == '0) || (rd_idx_reg + LEN_W'(1) >= len_rdata);
                if (out_ready)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.out_byte       = (len_rdata == '0) ? 8'd0 : byte_rdata;
                    rsp_next.out_last       = enq_last;
                    rsp_next.was_empty      = 1'b0;
                    rsp_next.dropped_oldest = 1'b0;
                    rsp_next.truncated      = 1'b0;
                    rsp_next.entries        = count_reg;
                    rsp_next.is_full        = (count_reg >= depth_reg);
                    rd_idx_next             = rd_idx_reg + LEN_W'(1);
                    mem_req.byte_raddr      = byte_addr(cur_slot_reg, rd_idx_reg + LEN_W'(1));
                    if (enq_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            depth_next     = cfg_depth;
            count_next     = '0;
            oldest_next    = '0;
            newest_next    = '0;
            writing_next   = 1'b0;
            offset_next    = '0;
            overflow_next  = 1'b0;
            overwrite_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            writing_reg   <= 1'b0;
            offset_reg    <= '0;
            overflow_reg  <= 1'b0;
            overwrite_reg <= 1'b0;
            depth_reg     <= CNT_W'(QUEUE_DEPTH);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            writing_reg   <= writing_next;
            offset_reg    <= offset_next;
            overflow_reg  <= overflow_next;
            overwrite_reg <= overwrite_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_slot_reg <= cur_slot_next;
        rd_idx_reg   <= rd_idx_next;
        rsp_reg      <= rsp_next;
    end

endmodule
`default_nettype wire

/* design/overwrite_oldest_message_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_oldest_message_fifo
// Ring FIFO of variable-length byte messages that drops the oldest when full.
// ----------------------------------------------------------------------------
// Enqueue, flush and close beats are handled without leaving the idle state,
// and a new enqueue byte can be accepted every cycle while the result output
// is not stalled. A dequeue first reads the slot length and first byte from
// the registered-read memories, then gives one result beat per cycle while
// the output is not stalled, during which no command is accepted. Output
// stall holds everything in place. Message storage is not cleared after
// reset; there is no clearing pass. Writing the depth flushes the queue.
module overwrite_oldest_message_fifo import ofifo_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire cmd_beat_t  cmd,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_beat_t       rsp,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    mem_req_t         mem_req;
    ctrl_status_t     status;
    logic [7:0]       byte_rdata;
    logic [LEN_W-1:0] len_rdata;

    ofifo_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (mem_req.byte_we),
        .waddr (mem_req.byte_waddr),
        .wdata (mem_req.byte_wdata),
        .raddr (mem_req.byte_raddr),
        .rdata (byte_rdata)
    );

    ofifo_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (mem_req.len_we),
        .waddr (mem_req.len_waddr),
        .wdata (mem_req.len_wdata),
        .raddr (mem_req.len_raddr),
        .rdata (len_rdata)
    );

    ofifo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mem_req    (mem_req),
        .byte_rdata (byte_rdata),
        .len_rdata  (len_rdata),
        .status     (status)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.entry_count <= status.depth)
        else $error("entry count exceeds depth");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> cmd_stall)
        else $error("command accepted while streaming");

    a_no_write_streaming: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> (!mem_req.byte_we && !mem_req.len_we))
        else $error("memory write during dequeue stream");

    a_empty_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.was_empty) |-> (rsp.entries == '0 && rsp.out_last))
        else $error("empty answer with stored entries");

endmodule
`default_nettype wire

/* tb/sv/tb_overwrite_oldest_message_fifo.sv */
// ----------------------------------------------------------------------------
// tb_overwrite_oldest_message_fifo
// Self-checking bench for the overwrite-oldest message FIFO: directed cases
// (empty dequeue, flush, close, open-message interrupts, overwrite at depth 1)
// then random message traffic over several depth settings, with bursty
// command beats and random response stall. Every response beat is checked
// field by field against an in-bench model of the queue.
// ----------------------------------------------------------------------------
module tb_overwrite_oldest_message_fifo;
    import ofifo_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_beat_t  cmd       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_beat_t  rsp;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    // queue model
    logic [7:0]  slot_data [QUEUE_DEPTH][MSG_BYTES];
    int unsigned slot_len  [QUEUE_DEPTH];
    int unsigned msg_cnt, head_slot, tail_slot, wr_off;
    bit          wr_open, trunc_flag, drop_flag;
    logic [7:0]  depth_reg;
    rsp_beat_t   rsp_due [$];

    int unsigned err_count  = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    overwrite_oldest_message_fifo u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned live_depth();
        if (depth_reg == 8'd0)
            return 1;
        if (depth_reg > QUEUE_DEPTH)
            return QUEUE_DEPTH;
        return depth_reg;
    endfunction

    function automatic int unsigned next_slot(input int unsigned s);
        return (s + 1 >= live_depth()) ? 0 : s + 1;
    endfunction

    function automatic void close_msg();
        wr_open    = 1'b0;
        wr_off     = 0;
        trunc_flag = 1'b0;
        drop_flag  = 1'b0;
    endfunction

    function automatic void clear_queue();
        msg_cnt   = 0;
        head_slot = 0;
        tail_slot = 0;
        close_msg();
    endfunction

    function automatic void push_rsp(input logic [7:0] b, input logic last, input logic empty,
                                     input logic drop, input logic trunc);
        rsp_beat_t r;
        r.out_byte       = b;
        r.out_last       = last;
        r.was_empty      = empty;
        r.dropped_oldest = drop;
        r.truncated      = trunc;
        r.entries        = CNT_W'(msg_cnt);
        r.is_full        = (msg_cnt >= live_depth());
        rsp_due.push_back(r);
    endfunction

    function automatic void apply_command(input cmd_beat_t c);
        int unsigned slot, n;
        if (c.opcode == OP_ENQUEUE)
        begin
            if (!wr_open)
            begin
                if (msg_cnt == 0)
                begin
                    head_slot = 0;
                    slot      = 0;
                end
                else
                    slot = next_slot(tail_slot);
                if (msg_cnt >= live_depth())
                begin
                    drop_flag = 1'b1;
                    head_slot = next_slot(slot);
                end
                else
                    msg_cnt++;
                tail_slot      = slot;
                slot_len[slot] = 0;
                wr_off         = 0;
                wr_open        = 1'b1;
            end
            if (wr_off < MSG_BYTES)
            begin
                slot_data[tail_slot][wr_off] = c.data_byte;
                wr_off++;
                slot_len[tail_slot] = wr_off;
            end
            else
                trunc_flag = 1'b1;
            push_rsp(8'h00, 1'b1, 1'b0, drop_flag, trunc_flag);
            if (c.end_of_message)
                close_msg();
            return;
        end
        close_msg();
        case (c.opcode)
            OP_FLUSH:
            begin
                clear_queue();
                push_rsp(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
            end
            OP_DEQUEUE:
            begin
                if (msg_cnt == 0)
                    push_rsp(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
                else
                begin
                    slot      = head_slot;
                    n         = (slot_len[slot] > MSG_BYTES) ? MSG_BYTES : slot_len[slot];
                    head_slot = next_slot(slot);
                    msg_cnt--;
                    if (n == 0)
                        push_rsp(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
                    for (int i = 0; i < n; i++)
                        push_rsp(slot_data[slot][i], i + 1 == n, 1'b0, 1'b0, 1'b0);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= 50)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_result(input rsp_beat_t got);
        rsp_beat_t want;
        if (rsp_due.size() == 0)
        begin
            note_mismatch($sformatf("result beat %h with none expected", got));
            return;
        end
        want = rsp_due.pop_front();
        cmp_field("out_byte", got.out_byte, want.out_byte);
        cmp_field("out_last", got.out_last, want.out_last);
        cmp_field("was_empty", got.was_empty, want.was_empty);
        cmp_field("dropped_oldest", got.dropped_oldest, want.dropped_oldest);
        cmp_field("truncated", got.truncated, want.truncated);
        cmp_field("entries", got.entries, want.entries);
        cmp_field("is_full", got.is_full, want.is_full);
    endtask

    // model update and response check, both sampled at the edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            depth_reg = 8'd128;
            clear_queue();
            rsp_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                depth_reg = cfg_wdata;
                clear_queue();
            end
            if (cmd_valid && !cmd_stall)
                apply_command(cmd);
            if (rsp_valid && !rsp_stall)
                check_result(rsp);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[overwrite_oldest_message_fifo] ERROR");
            $finish;
        end
    end

    task automatic send_beat(input opcode_t op, input logic [7:0] b, input logic eom);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= '{op, b, eom};
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        beats_sent++;
    endtask

    task automatic cmd_idle();
        cmd_valid <= 1'b0;
    endtask

    task automatic write_depth(input logic [7:0] value);
        cmd_idle();
        // let the model take the last accepted beat before looking at the queue
        @(posedge clk);
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_message(input int unsigned len, input bit closed);
        for (int i = 0; i < len; i++)
            send_beat(OP_ENQUEUE, 8'($urandom_range(0, 255)), closed && (i + 1 == len));
    endtask

    function automatic int unsigned msg_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 4);
        if (r < 94)
            return $urandom_range(5, 20);
        return $urandom_range(60, 70);
    endfunction

    task automatic test_empty_queue();
        send_beat(OP_DEQUEUE, 8'hFF, 1'b1);
        send_beat(OP_FLUSH, 8'h00, 1'b0);
        send_beat(OP_CLOSE, 8'hA5, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(OP_ENQUEUE, 8'h00, 1'b0);
        send_beat(OP_ENQUEUE, 8'hFF, 1'b1);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
    endtask

    task automatic test_close_open_message();
        send_beat(OP_ENQUEUE, 8'hAA, 1'b0);
        send_beat(OP_ENQUEUE, 8'h55, 1'b0);
        send_beat(OP_CLOSE, 8'h00, 1'b0);
        send_beat(OP_ENQUEUE, 8'h0F, 1'b1);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
    endtask

    task automatic test_flush_open_message();
        send_beat(OP_ENQUEUE, 8'h12, 1'b0);
        send_beat(OP_FLUSH, 8'h00, 1'b0);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
    endtask

    task automatic test_overwrite_oldest();
        write_depth(8'd1);
        send_beat(OP_ENQUEUE, 8'h01, 1'b1);
        send_beat(OP_ENQUEUE, 8'h02, 1'b0);
        send_beat(OP_ENQUEUE, 8'h03, 1'b1);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
        send_beat(OP_ENQUEUE, 8'h7E, 1'b0);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
        send_beat(OP_DEQUEUE, 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic();
        logic [7:0]  depths [8];
        int unsigned pick, phase_end;
        depths    = '{8'd2, 8'd0, 8'd3, 8'd255, 8'd1, 8'd6, 8'd128, 8'd0};
        depths[7] = 8'($urandom_range(1, 12));
        foreach (depths[p])
        begin
            write_depth(depths[p]);
            // at least one message past slot capacity
            if (p == 0)
                send_message($urandom_range(65, 70), 1'b1);
            phase_end = beats_sent + 30;
            while (beats_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_message(msg_len(), 1'b1);
                else if (pick < 75)
                    send_beat(OP_DEQUEUE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else if (pick < 83)
                    send_message(msg_len(), 1'b0);
                else if (pick < 88)
                    send_beat(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else if (pick < 92)
                    send_beat(OP_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                else
                    send_beat(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_empty_queue();
        test_byte_extremes();
        test_close_open_message();
        test_flush_open_message();
        test_overwrite_oldest();
        test_random_traffic();

        cmd_idle();
        @(posedge clk);
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("[overwrite_oldest_message_fifo] OK");
        else
            $display("[overwrite_oldest_message_fifo] ERROR");
        $finish;
    end

endmodule
